FILE: src/mtf_pkg.sv
package mtf_pkg;

    // Width of a symbol on the ports.
    localparam int unsigned SYM_W = 8;

    // Default list length.
    localparam int unsigned DEF_ALPHABET_SIZE = 256;

    // Number of cells folded into one registered group of the result reduction.
    localparam int unsigned GROUP_SIZE = 16;

    // Configuration register indexes.
    localparam logic REG_IDX_DIRECTION = 1'b0;

    // Controls broadcast from the sequencer to every list cell.
    typedef struct packed {
        logic             load_id;   // restore identity order
        logic             cmp_en;    // capture the match flag
        logic             dir;       // 1 matches on cell index, 0 on cell contents
        logic [SYM_W-1:0] key;       // symbol or saturated index to match
        logic             shift_en;  // perform the move to front
        logic [SYM_W-1:0] pos;       // position of the symbol being moved
    } cell_ctrl_t;

endpackage

FILE: src/mtf_cell.sv
module mtf_cell #(
    parameter int unsigned ALPHABET_SIZE = mtf_pkg::DEF_ALPHABET_SIZE,
    parameter int unsigned INDEX         = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mtf_pkg::cell_ctrl_t              ctrl,
    input  logic [$clog2(ALPHABET_SIZE)-1:0] prev_entry,
    output logic [$clog2(ALPHABET_SIZE)-1:0] entry,
    output logic                             match
);
    import mtf_pkg::*;

    localparam int unsigned     POS_W   = $clog2(ALPHABET_SIZE);
    localparam logic [SYM_W-1:0] IDX_SYM = SYM_W'(INDEX);
    localparam logic [POS_W-1:0] IDX_POS = POS_W'(INDEX);

    logic [POS_W-1:0] entry_reg;
    logic [POS_W-1:0] entry_next;
    logic             match_reg;
    logic             match_next;

    // The cell takes its neighbor's entry when the moved symbol sat at or behind it.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.load_id) begin
            entry_next = IDX_POS;
        end else if (ctrl.shift_en && (IDX_SYM <= ctrl.pos)) begin
            entry_next = prev_entry;
        end
    end

    // Decoding selects by position, encoding by contents.
    always_comb begin
        match_next = match_reg;
        if (ctrl.cmp_en) begin
            if (ctrl.dir) begin
                match_next = (IDX_SYM == ctrl.key);
            end else begin
                match_next = (SYM_W'(entry_reg) == ctrl.key);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= IDX_POS;
            match_reg <= 1'b0;
        end else begin
            entry_reg <= entry_next;
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

FILE: src/mtf_reduce.sv
module mtf_reduce #(
    parameter int unsigned ALPHABET_SIZE = mtf_pkg::DEF_ALPHABET_SIZE
) (
    input  logic                                                aclk,
    input  logic [ALPHABET_SIZE-1:0]                            match,
    input  logic [ALPHABET_SIZE-1:0][$clog2(ALPHABET_SIZE)-1:0] entries,
    output logic                                                hit,
    output logic [$clog2(ALPHABET_SIZE)-1:0]                    pos,
    output logic [$clog2(ALPHABET_SIZE)-1:0]                    sym
);
    import mtf_pkg::*;

    localparam int unsigned POS_W  = $clog2(ALPHABET_SIZE);
    localparam int unsigned NGRP   = (ALPHABET_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int unsigned PAD_N  = NGRP * GROUP_SIZE;

    logic [PAD_N-1:0]            match_pad;
    logic [PAD_N-1:0][POS_W-1:0] ent_pad;

    logic [NGRP-1:0]             grp_hit_reg;
    logic [NGRP-1:0]             grp_hit_next;
    logic [NGRP-1:0][POS_W-1:0]  grp_pos_reg;
    logic [NGRP-1:0][POS_W-1:0]  grp_pos_next;
    logic [NGRP-1:0][POS_W-1:0]  grp_sym_reg;
    logic [NGRP-1:0][POS_W-1:0]  grp_sym_next;

    // Pad the cell row up to a whole number of groups; padding never matches.
    assign match_pad = PAD_N'(match);

    for (genvar i = 0; i < PAD_N; i++) begin : g_pad
        if (i < ALPHABET_SIZE) begin : g_real
            assign ent_pad[i] = entries[i];
        end else begin : g_fill
            assign ent_pad[i] = '0;
        end
    end

    // First level: the matching cell's position and contents within each group.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_hit_next[g] = 1'b0;
            grp_pos_next[g] = '0;
            grp_sym_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (match_pad[g*GROUP_SIZE + k]) begin
                    grp_hit_next[g] = 1'b1;
                    grp_pos_next[g] = grp_pos_next[g] | POS_W'(g*GROUP_SIZE + k);
                    grp_sym_next[g] = grp_sym_next[g] | ent_pad[g*GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_hit_reg <= grp_hit_next;
        grp_pos_reg <= grp_pos_next;
        grp_sym_reg <= grp_sym_next;
    end

    // Second level: combine the groups; at most one of them holds the match.
    always_comb begin
        hit = 1'b0;
        pos = '0;
        sym = '0;
        for (int g = 0; g < NGRP; g++) begin
            hit = hit | grp_hit_reg[g];
            pos = pos | grp_pos_reg[g];
            sym = sym | grp_sym_reg[g];
        end
    end

endmodule

FILE: src/move_to_front_coder.sv
// Move-to-front coder over a list of ALPHABET_SIZE symbols held in a row of cells,
// one list entry per cell. With direction at 0 each byte is replaced by its current
// rank in the list; with direction at 1 each beat carries a rank and the symbol at
// that rank comes out (ranks past the end select the last entry). Either way the
// symbol then moves to the front while the cells ahead of it each take their
// neighbor's entry. A beat with s_block_start set restores the identity order first.
// Encoding a byte outside the alphabet returns the byte and leaves the list alone.
// One item is in flight at a time. After the accepting edge every cell compares in
// parallel, then the reduction finds the matching cell, first within each group into
// registers and then across the groups in the final step, which also moves the list
// and loads the output register. A new beat is accepted only once the previous item
// has finished, and the final step stalls while the output register holds a result not yet taken.
// The next item is accepted while a finished result still waits in the output register.
module move_to_front_coder #(
    parameter int unsigned ALPHABET_SIZE = mtf_pkg::DEF_ALPHABET_SIZE
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // Input channel.
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [mtf_pkg::SYM_W-1:0] s_symbol_in,
    input  logic                      s_block_start,
    // Result channel.
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [mtf_pkg::SYM_W-1:0] m_symbol_out
);
    import mtf_pkg::*;

    localparam int unsigned      POS_W    = $clog2(ALPHABET_SIZE);
    localparam logic [SYM_W-1:0] LAST_IDX = SYM_W'(ALPHABET_SIZE - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_RED  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             dir_reg;
    logic             dir_next;
    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [SYM_W-1:0] m_symbol_out_reg;
    logic [SYM_W-1:0] m_symbol_out_next;

    logic             s_accept;
    logic             fin_fire;
    logic             cfg_write;
    logic [SYM_W-1:0] key;
    cell_ctrl_t       ctrl;

    logic [ALPHABET_SIZE-1:0]            cell_match;
    logic [ALPHABET_SIZE-1:0][POS_W-1:0] cell_entry;
    logic [ALPHABET_SIZE-1:0][POS_W-1:0] cell_prev;
    logic                                red_hit;
    logic [POS_W-1:0]                    red_pos;
    logic [POS_W-1:0]                    red_sym;

    // Configuration port: zero wait states, the direction register at index zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_IDX_DIRECTION);
    assign dir_next  = cfg_write ? pwdata[0] : dir_reg;
    assign prdata    = (paddr[2] == REG_IDX_DIRECTION) ? 32'(dir_reg) : '0;

    // Handshakes.
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign fin_fire = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    assign sym_next = s_accept ? s_symbol_in : sym_reg;

    // Decode ranks past the end of the list saturate to the last entry.
    always_comb begin
        key = sym_reg;
        if (dir_reg && (sym_reg > LAST_IDX)) begin
            key = LAST_IDX;
        end
    end

    // Sequencer: capture, compare, reduce, then update the list.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_RED;
            end
            ST_RED: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (fin_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controls broadcast to the cell row.
    always_comb begin
        ctrl.load_id  = s_accept && s_block_start;
        ctrl.cmp_en   = (state_reg == ST_CMP);
        ctrl.dir      = dir_reg;
        ctrl.key      = key;
        ctrl.shift_en = fin_fire && red_hit;
        ctrl.pos      = SYM_W'(red_pos);
    end

    // Cell row: cell zero takes the moved symbol, every other cell its neighbor's entry.
    for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign cell_prev[i] = red_sym;
        end else begin : g_body
            assign cell_prev[i] = cell_entry[i-1];
        end

        mtf_cell #(
            .ALPHABET_SIZE (ALPHABET_SIZE),
            .INDEX         (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_entry (cell_prev[i]),
            .entry      (cell_entry[i]),
            .match      (cell_match[i])
        );
    end

    // Find the matching cell's position and contents.
    mtf_reduce #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_reduce (
        .aclk    (aclk),
        .match   (cell_match),
        .entries (cell_entry),
        .hit     (red_hit),
        .pos     (red_pos),
        .sym     (red_sym)
    );

    // Output register: rank when encoding, symbol when decoding, the byte on a miss.
    always_comb begin
        m_valid_next      = m_valid_reg;
        m_symbol_out_next = m_symbol_out_reg;
        if (fin_fire) begin
            m_valid_next = 1'b1;
            if (!red_hit) begin
                m_symbol_out_next = sym_reg;
            end else if (dir_reg) begin
                m_symbol_out_next = SYM_W'(red_sym);
            end else begin
                m_symbol_out_next = SYM_W'(red_pos);
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dir_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dir_reg     <= dir_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg          <= sym_next;
        m_symbol_out_reg <= m_symbol_out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_symbol_out = m_symbol_out_reg;

`ifndef ASSERT_OFF
    // Only one item is worked on at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new beat accepted while an item is in flight");

    // The list is a permutation, so at most one cell can match.
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RED) |-> $onehot0(cell_match))
        else $error("more than one list cell matched");

    // A decode index always selects some cell.
    a_decode_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) && dir_reg |-> red_hit)
        else $error("decode found no list entry");

    // A finished item is presented on the result channel.
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_fire |=> m_valid)
        else $error("finished item did not reach the output register");
`endif

endmodule
